// ----- hw/rtl/wpd_pkg.sv -----
// Shared types and constants for the waypoint path densifier.
`timescale 1ns / 1ps
package wpd_pkg;

  localparam int SPACING_W = 23;
  localparam logic [SPACING_W-1:0] SPACING_RST = 23'd655;

  // Axis lane codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_ORIGIN   = 2'd0,
    KIND_INTERIOR = 2'd1,
    KIND_END      = 2'd2
  } kind_t;

  // Divider operand select
  typedef enum logic {
    SEL_LEN  = 1'b0,
    SEL_AXIS = 1'b1
  } div_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       diff;
    logic       sq_en;
    logic [1:0] axis;
    logic       acc_add;
    logic       sqrt_start;
    logic       div_start;
    div_sel_t   div_sel;
    logic       div_take;
    logic       step;
    logic       out_load;
    kind_t      out_kind;
    logic       out_last;
  } wpd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic first;
    logic seg_zero;
    logic n_zero;
    logic j_last;
    logic sqrt_done;
    logic div_done;
  } wpd_stat_t;

endpackage

// ----- hw/rtl/waypoint_path_densifier.sv -----
// Top level of the waypoint path densifier: controller plus datapath.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------
//  input   | in_first in_px in_py in_pz              | in_valid/in_stall
//  result  | out_ox out_oy out_oz out_kind out_capped | out_valid/out_stall
//          | out_last                                |
//  config  | cfg_wdata (spacing)                     | cfg_we
//
// After its accept, a waypoint with a non-zero segment is set up by three squares on
// one multiplier, a bit-serial root and four passes of one bit-serial divider; then
// the origin (first waypoint only), the interior points and the end point are
// emitted, each beat waiting while the result is stalled.
// The output register lets the next waypoint be accepted while the last beat waits.
// Reset (rst_n low, synchronous) clears control and the previous point and sets the spacing to its reset value.
// A stalled result holds the emitting state; no beat is dropped or repeated.
`timescale 1ns / 1ps
module waypoint_path_densifier
  import wpd_pkg::*;
#(
  parameter int COORD_BITS   = 24,
  parameter int MAX_INTERIOR = 62
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_first,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic signed [COORD_BITS-1:0] in_pz,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_ox,
  output logic signed [COORD_BITS-1:0] out_oy,
  output logic signed [COORD_BITS-1:0] out_oz,
  output logic [1:0]                   out_kind,
  output logic                         out_capped,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [SPACING_W-1:0]         cfg_wdata
);
  wpd_cmd_t  cmd;
  wpd_stat_t stat;

  wpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  wpd_dp #(
    .COORD_BITS   (COORD_BITS),
    .MAX_INTERIOR (MAX_INTERIOR)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_first   (in_first),
    .in_px      (in_px),
    .in_py      (in_py),
    .in_pz      (in_pz),
    .out_ox     (out_ox),
    .out_oy     (out_oy),
    .out_oz     (out_oz),
    .out_kind   (out_kind),
    .out_capped (out_capped),
    .out_last   (out_last)
  );

`ifndef SYNTHESIS
  // An accepted waypoint keeps the input side busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // Interior points never close a waypoint's beats
  a_interior_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_INTERIOR)) |-> !out_last)
    else $error("interior beat flagged last");

  // End points always close a waypoint's beats
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_END)) |-> out_last)
    else $error("end beat not flagged last");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_ox) && $stable(out_kind)))
    else $error("stalled result changed");
`endif

endmodule

// ----- hw/rtl/wpd_sqrt.sv -----
// Iterative restoring integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module wpd_sqrt #(
  parameter int XW = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [XW-1:0]   x,
  output logic            done,
  output logic [XW/2-1:0] root
);
  localparam int RW = XW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [XW-1:0] x_r, x_nxt;
  logic [RW+1:0] rem_r, rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [RW+1:0] rem_sh, trial;
  logic          ge;

  // One iteration: bring down two bits, try root*4+1
  always_comb begin
    rem_sh   = {rem_r[RW-1:0], x_r[XW-1:XW-2]};
    trial    = {root_r, 2'b01};
    ge       = rem_sh >= trial;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt    = {x_r[XW-3:0], 2'b00};
      rem_nxt  = ge ? rem_sh - trial : rem_sh;
      root_nxt = {root_r[RW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- hw/rtl/wpd_div.sv -----
// Iterative restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wpd_div #(
  parameter int NW = 25,
  parameter int DW = 23
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   sh, diff;
  logic          ge;

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    sh       = {rem_r, q_r[NW-1]};
    diff     = sh - {1'b0, dvs_r};
    ge       = sh >= {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : sh[DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/wpd_dp.sv -----
// Datapath: point registers, squares, root and divider units, stepping lanes, output beat.
`timescale 1ns / 1ps
module wpd_dp
  import wpd_pkg::*;
#(
  parameter int COORD_BITS   = 24,
  parameter int MAX_INTERIOR = 62
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wpd_cmd_t                     cmd,
  output wpd_stat_t                    stat,
  input  logic                         cfg_we,
  input  logic [SPACING_W-1:0]         cfg_wdata,
  input  logic                         in_first,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic signed [COORD_BITS-1:0] in_pz,
  output logic signed [COORD_BITS-1:0] out_ox,
  output logic signed [COORD_BITS-1:0] out_oy,
  output logic signed [COORD_BITS-1:0] out_oz,
  output logic [1:0]                   out_kind,
  output logic                         out_capped,
  output logic                         out_last
);
  localparam int C  = COORD_BITS;
  localparam int SW = 2 * C + 2;
  localparam int RW = C + 1;
  localparam int NW = $clog2(MAX_INTERIOR + 2);

  logic [SPACING_W-1:0]  spacing_r;
  logic signed [C-1:0]   e_r [3];
  logic signed [C-1:0]   s_r [3];
  logic signed [C:0]     d_r [3];
  logic [C-1:0]          mag [3];
  logic                  first_r;
  logic [SW-1:0]         acc_r;
  logic [2*C-1:0]        prod_r;
  logic [NW-1:0]         n_r;
  logic                  capped_r;
  logic [C-1:0]          qq_r [3];
  logic [NW-1:0]         rr_r [3];
  logic [C-1:0]          qa_r [3];
  logic [NW-1:0]         ra_r [3];
  logic [NW-1:0]         j_r;
  logic signed [C-1:0]   o_r [3];
  kind_t                 kind_r;
  logic                  last_r;
  logic                  capped_o_r;

  logic [NW:0]           np1;
  logic [NW:0]           ra_sum [3];
  logic                  ra_ge [3];
  logic signed [C:0]     pt [3];
  logic                  sqrt_done;
  logic [RW-1:0]         root;
  logic                  div_done;
  logic [RW-1:0]         div_n, quot;
  logic [SPACING_W-1:0]  div_d, rem;
  logic [SPACING_W-1:0]  sp_eff;
  logic signed [C-1:0]   in_p [3];

  assign in_p[0] = in_px;
  assign in_p[1] = in_py;
  assign in_p[2] = in_pz;

  // Magnitudes of the segment deltas
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = d_r[a][C] ? C'(-d_r[a]) : C'(d_r[a]);
    end
  end

  // Stepping lanes: add q and r per point, carry when the remainder wraps
  assign np1 = {1'b0, n_r} + 1'b1;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ra_sum[a] = {1'b0, ra_r[a]} + {1'b0, rr_r[a]};
      ra_ge[a]  = ra_sum[a] >= np1;
      pt[a]     = d_r[a][C] ? ({s_r[a][C-1], s_r[a]} - $signed({1'b0, qa_r[a]}))
                            : ({s_r[a][C-1], s_r[a]} + $signed({1'b0, qa_r[a]}));
    end
  end

  // Shared divider operands
  assign sp_eff = (spacing_r == '0) ? SPACING_W'(1) : spacing_r;
  always_comb begin
    if (cmd.div_sel == SEL_AXIS) begin
      div_n = {1'b0, mag[cmd.axis]};
      div_d = SPACING_W'(np1);
    end else begin
      div_n = root;
      div_d = sp_eff;
    end
  end

  wpd_sqrt #(.XW(SW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .x     (acc_r),
    .done  (sqrt_done),
    .root  (root)
  );

  wpd_div #(.NW(RW), .DW(SPACING_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // Config register and previous waypoint
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RST;
      for (int a = 0; a < 3; a++) e_r[a] <= '0;
    end else begin
      if (cfg_we) spacing_r <= cfg_wdata;
      if (cmd.accept) begin
        for (int a = 0; a < 3; a++) e_r[a] <= in_p[a];
      end
    end
  end

  // Segment working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      first_r <= in_first;
      for (int a = 0; a < 3; a++) s_r[a] <= in_first ? '0 : e_r[a];
    end
    if (cmd.diff) begin
      for (int a = 0; a < 3; a++) begin
        d_r[a]  <= {e_r[a][C-1], e_r[a]} - {s_r[a][C-1], s_r[a]};
        qa_r[a] <= '0;
        ra_r[a] <= '0;
      end
      acc_r    <= '0;
      prod_r   <= '0;
      j_r      <= '0;
      n_r      <= '0;
      capped_r <= 1'b0;
    end
    if (cmd.sq_en) prod_r <= mag[cmd.axis] * mag[cmd.axis];
    if (cmd.acc_add) acc_r <= acc_r + SW'(prod_r);
    if (cmd.div_take) begin
      if (cmd.div_sel == SEL_AXIS) begin
        qq_r[cmd.axis] <= quot[C-1:0];
        rr_r[cmd.axis] <= rem[NW-1:0];
      end else if (quot > RW'(MAX_INTERIOR)) begin
        n_r      <= NW'(MAX_INTERIOR);
        capped_r <= 1'b1;
      end else begin
        n_r <= quot[NW-1:0];
      end
    end
    if (cmd.step) begin
      for (int a = 0; a < 3; a++) begin
        ra_r[a] <= ra_ge[a] ? NW'(ra_sum[a] - np1) : ra_sum[a][NW-1:0];
        qa_r[a] <= qa_r[a] + qq_r[a] + C'(ra_ge[a]);
      end
      j_r <= j_r + 1'b1;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int a = 0; a < 3; a++) begin
        case (cmd.out_kind)
          KIND_ORIGIN:   o_r[a] <= '0;
          KIND_INTERIOR: o_r[a] <= pt[a][C-1:0];
          default:       o_r[a] <= e_r[a];
        endcase
      end
      kind_r     <= cmd.out_kind;
      last_r     <= cmd.out_last;
      capped_o_r <= capped_r;
    end
  end

  assign out_ox     = o_r[0];
  assign out_oy     = o_r[1];
  assign out_oz     = o_r[2];
  assign out_kind   = kind_r;
  assign out_capped = capped_o_r;
  assign out_last   = last_r;

  assign stat.first     = first_r;
  assign stat.seg_zero  = (acc_r == '0);
  assign stat.n_zero    = (n_r == '0);
  assign stat.j_last    = (j_r == n_r);
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;

endmodule

// ----- hw/rtl/wpd_ctrl.sv -----
// Controller: sequences squares, root, divisions and point emission.
`timescale 1ns / 1ps
module wpd_ctrl
  import wpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  wpd_stat_t stat,
  output wpd_cmd_t  cmd
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_SQ, ST_SQEND, ST_ROOT_GO, ST_ROOT_WAIT,
    ST_DIVN_GO, ST_DIVN_WAIT, ST_DIVA_GO, ST_DIVA_WAIT,
    ST_ORIGIN, ST_STEP, ST_INTER, ST_ENDPT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    cmd.axis      = ax_r;
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        ax_nxt    = AXIS_X;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_en   = 1'b1;
        cmd.acc_add = 1'b1;
        if (ax_r == AXIS_Z) begin
          state_nxt = ST_SQEND;
        end else begin
          ax_nxt = ax_r + 1'b1;
        end
      end
      ST_SQEND: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        if (stat.seg_zero) begin
          state_nxt = stat.first ? ST_ORIGIN : ST_IDLE;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_ROOT_WAIT;
        end
      end
      ST_ROOT_WAIT: begin
        if (stat.sqrt_done) state_nxt = ST_DIVN_GO;
      end
      ST_DIVN_GO: begin
        cmd.div_sel   = SEL_LEN;
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVN_WAIT;
      end
      ST_DIVN_WAIT: begin
        cmd.div_sel = SEL_LEN;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          ax_nxt       = AXIS_X;
          state_nxt    = ST_DIVA_GO;
        end
      end
      ST_DIVA_GO: begin
        cmd.div_sel   = SEL_AXIS;
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVA_WAIT;
      end
      ST_DIVA_WAIT: begin
        cmd.div_sel = SEL_AXIS;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          if (ax_r == AXIS_Z) begin
            if (stat.first) state_nxt = ST_ORIGIN;
            else state_nxt = stat.n_zero ? ST_ENDPT : ST_STEP;
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = ST_DIVA_GO;
          end
        end
      end
      ST_ORIGIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ORIGIN;
          cmd.out_last = stat.seg_zero;
          if (stat.seg_zero) state_nxt = ST_IDLE;
          else state_nxt = stat.n_zero ? ST_ENDPT : ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_INTER;
      end
      ST_INTER: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_INTERIOR;
          state_nxt    = stat.j_last ? ST_ENDPT : ST_STEP;
        end
      end
      ST_ENDPT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_END;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
